// ===== rtl/swsat_pkg.sv =====
package swsat_pkg;

    localparam int unsigned MIN_LEN_W  = 11;
    localparam int unsigned OUT_DATA_W = 16;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DROP_RD = 7'b0000010,
        S_DROP    = 7'b0000100,
        S_PUSH    = 7'b0001000,
        S_CHECK   = 7'b0010000,
        S_POP     = 7'b0100000,
        S_EMIT    = 7'b1000000
    } t_state;

endpackage

// ===== rtl/smallest_window_sum_above_threshold.sv =====
// Channel   Dir  Signals                          Contents
// s_axis    in   tvalid/tready/tdata/tlast        tdata: value; tlast: is_last
// m_axis    out  tvalid/tready/tdata/tuser        tdata: min_length; tuser: window_truncated
// cfg       in   valid/ready/data                 threshold
//
// An item is pushed and added to the sum, then checked; while the sum is above the
// threshold, the oldest element is read and subtracted (the store has one port pair)
// and the window rechecked. A full window first drops its oldest; tlast loads the result.
// Reset (synchronous, active low) clears pointers, count, sum, best length and flags.
// The result sits in an output register; a last item waits only if that register is full.
module smallest_window_sum_above_threshold #(
    parameter int unsigned MAX_LEN    = 1024,
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [VALUE_BITS-1:0] value, rest zero
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [10:0] min_length, rest zero
    output logic [swsat_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // [0] window_truncated
    output logic                                o_m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [31:0]                         i_cfg_data
);
    import swsat_pkg::*;

    localparam int unsigned AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned CW   = $clog2(MAX_LEN + 1);
    localparam int unsigned SW   = VALUE_BITS + CW;
    localparam int unsigned CMPW = (SW > 32) ? SW : 32;

    t_state r_state, n_state;

    logic [VALUE_BITS-1:0] r_mem [MAX_LEN];
    logic [VALUE_BITS-1:0] r_rd_data;

    logic [31:0]           r_threshold;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_last;
    logic [AW-1:0]         r_head, n_head;
    logic [AW-1:0]         r_tail, n_tail;
    logic [CW-1:0]         r_count, n_count;
    logic [SW-1:0]         r_sum, n_sum;
    logic [CW-1:0]         r_best, n_best;
    logic                  r_found, n_found;
    logic                  r_trunc, n_trunc;
    logic                  r_out_valid, n_out_valid;
    logic [MIN_LEN_W-1:0]  r_out_len, n_out_len;
    logic                  r_out_trunc, n_out_trunc;

    logic                  in_acc;
    logic                  out_free;
    logic                  above;
    logic [SW-1:0]         alu_opnd;
    logic                  alu_sub;
    logic [SW-1:0]         alu_res;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_out_len);
    assign o_m_axis_tuser  = r_out_trunc;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign above    = (r_count != '0) && (CMPW'(r_sum) > CMPW'(r_threshold));

    // shared add/subtract unit for the running sum
    assign alu_sub  = (r_state == S_DROP) || (r_state == S_POP);
    assign alu_opnd = alu_sub ? SW'(r_rd_data) : SW'(r_val);
    assign alu_res  = alu_sub ? (r_sum - alu_opnd) : (r_sum + alu_opnd);

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH) begin
            r_mem[r_tail] <= r_val;
        end
        r_rd_data <= r_mem[r_head];
        if (in_acc) begin
            r_val  <= i_s_axis_tdata[VALUE_BITS-1:0];
            r_last <= i_s_axis_tlast;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_sum       = r_sum;
        n_best      = r_best;
        n_found     = r_found;
        n_trunc     = r_trunc;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_len   = r_out_len;
        n_out_trunc = r_out_trunc;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (r_count == CW'(MAX_LEN)) ? S_DROP_RD : S_PUSH;
                end
            end
            S_DROP_RD: begin
                n_state = S_DROP;
            end
            S_DROP: begin
                n_sum   = alu_res;
                n_head  = (r_head == AW'(MAX_LEN - 1)) ? '0 : r_head + 1'b1;
                n_count = r_count - 1'b1;
                n_trunc = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                n_sum   = alu_res;
                n_tail  = (r_tail == AW'(MAX_LEN - 1)) ? '0 : r_tail + 1'b1;
                n_count = r_count + 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (above) begin
                    if (!r_found || (r_count < r_best)) begin
                        n_best  = r_count;
                        n_found = 1'b1;
                    end
                    n_state = S_POP;
                end else begin
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_POP: begin
                n_sum   = alu_res;
                n_head  = (r_head == AW'(MAX_LEN - 1)) ? '0 : r_head + 1'b1;
                n_count = r_count - 1'b1;
                n_state = S_CHECK;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_len   = r_found ? MIN_LEN_W'(r_best) : '0;
                    n_out_trunc = r_trunc;
                    n_head      = '0;
                    n_tail      = '0;
                    n_count     = '0;
                    n_sum       = '0;
                    n_best      = '0;
                    n_found     = 1'b0;
                    n_trunc     = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_threshold <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_best      <= '0;
            r_found     <= 1'b0;
            r_trunc     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_threshold <= i_cfg_data;
            end
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_best      <= n_best;
            r_found     <= n_found;
            r_trunc     <= n_trunc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_len   <= n_out_len;
        r_out_trunc <= n_out_trunc;
    end

endmodule

// ===== tb/sv/smallest_window_sum_above_threshold_tb.sv =====
module smallest_window_sum_above_threshold_tb;
    import swsat_pkg::*;

    localparam int unsigned WIN_DEPTH     = 1024;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [MIN_LEN_W-1:0] min_len;
        logic                 truncated;
    } t_window_result;

    // Two-pointer window model; one expected result per closed sequence.
    class shortest_window_tracker;
        logic [15:0]     win_vals [WIN_DEPTH];
        int unsigned     oldest;
        int unsigned     next_free;
        int unsigned     fill;
        int unsigned     shortest;
        longint unsigned total;
        bit              have_shortest;
        bit              dropped;
        logic [31:0]     threshold = '0;
        t_window_result  expected_results [$];
        int unsigned     mismatch_count;

        function void drop_oldest();
            if (fill == 0) return;
            total -= win_vals[oldest];
            oldest = (oldest + 1) % WIN_DEPTH;
            fill--;
        endfunction

        function void clear_window();
            oldest = 0;
            next_free = 0;
            fill = 0;
            total = 0;
            shortest = 0;
            have_shortest = 1'b0;
            dropped = 1'b0;
        endfunction

        function void note_value(logic [15:0] v, logic last);
            t_window_result res;
            if (fill >= WIN_DEPTH) begin
                drop_oldest();
                dropped = 1'b1;
            end
            win_vals[next_free] = v;
            next_free = (next_free + 1) % WIN_DEPTH;
            fill++;
            total += v;
            while (fill > 0 && total > threshold) begin
                if (!have_shortest || fill < shortest) begin
                    shortest = fill;
                    have_shortest = 1'b1;
                end
                drop_oldest();
            end
            if (last) begin
                res.min_len = have_shortest ? MIN_LEN_W'(shortest) : '0;
                res.truncated = dropped;
                expected_results.push_back(res);
                clear_window();
            end
        endfunction

        function void check_result(logic [MIN_LEN_W-1:0] len, logic trunc);
            t_window_result want;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: min_length %0d truncated %0b", len, trunc);
                return;
            end
            want = expected_results.pop_front();
            if (want.min_len !== len || want.truncated !== trunc) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: expected min_length %0d truncated %0b, got %0d %0b",
                             want.min_len, want.truncated, len, trunc);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [15:0]           i_s_axis_tdata  = '0;   // [15:0] value
    logic                  i_s_axis_tlast  = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;         // [10:0] min_length, rest zero
    logic                  o_m_axis_tuser;         // [0] window_truncated
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [31:0]           i_cfg_data      = '0;

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned cycles       = 0;

    shortest_window_tracker sb;

    smallest_window_sum_above_threshold dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata[MIN_LEN_W-1:0], o_m_axis_tuser);
    end

    task automatic write_threshold(input logic [31:0] t);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= t;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.threshold = t;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic [15:0] v, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= v;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_value(v, last);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_value();
        int unsigned r;
        r = $urandom_range(19);
        if (r < 3) return 16'd0;
        if (r < 5) return 16'hFFFF;
        if (r < 10) return 16'($urandom_range(255));
        return 16'($urandom_range(65535));
    endfunction

    // Mostly short sequences, some longer; the phase always closes a sequence.
    task automatic random_sequences(input int unsigned n_items);
        int unsigned i;
        int unsigned left;
        left = 0;
        for (i = 0; i < n_items; i++) begin
            if (left == 0)
                left = ($urandom_range(9) == 0) ? $urandom_range(25, 60)
                                                : $urandom_range(1, 20);
            left--;
            send_item(pick_value(), (left == 0) || (i == n_items - 1));
        end
    endtask

    initial begin
        int unsigned i;
        int unsigned mode;
        int unsigned k;
        int unsigned tx_pct [4];
        int unsigned rx_pct [4];
        tx_pct = '{0, 45, 0, 14};
        rx_pct = '{0, 0, 45, 14};
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero threshold: any nonzero value qualifies alone
        write_threshold(32'd0);
        send_item(16'd0, 1'b0);
        send_item(16'd0, 1'b1);
        send_item(16'hFFFF, 1'b1);
        send_item(16'd0, 1'b0);
        send_item(16'd0, 1'b0);
        send_item(16'd1, 1'b1);
        send_item(16'd0, 1'b1);
        drain();

        // unreachable threshold
        write_threshold(32'hFFFF_FFFF);
        repeat (3) send_item(16'hFFFF, 1'b0);
        send_item(16'hFFFF, 1'b1);
        drain();

        // full window: leading zeros fall off, then only the whole window qualifies
        write_threshold((WIN_DEPTH - 1) * 32'd65535);
        repeat (6) send_item(16'd0, 1'b0);
        for (i = 0; i < WIN_DEPTH; i++) send_item(16'hFFFF, i == WIN_DEPTH - 1);
        drain();

        write_threshold(32'd100);
        send_item(16'd50, 1'b0);
        send_item(16'd60, 1'b0);
        send_item(16'd200, 1'b0);
        send_item(16'd1, 1'b0);
        send_item(16'd99, 1'b1);
        drain();

        for (mode = 0; mode < 4; mode++) begin
            tx_idle_pct  = tx_pct[mode];
            rx_stall_pct = rx_pct[mode];
            for (k = 0; k < 2; k++) begin
                write_threshold((k == 0) ? $urandom_range(0, 70000)
                                         : $urandom_range(70000, 1500000));
                random_sequences(25);
                drain();
            end
        end

        if (sb.mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/swsat_pkg.sv
rtl/smallest_window_sum_above_threshold.sv
tb/sv/smallest_window_sum_above_threshold_tb.sv
